// ===== src/dfa_rec_pkg.sv =====
package dfa_rec_pkg;

    // Table geometry and limits
    localparam int ARC_ENTRIES   = 128;
    localparam int EPSILON_LIMIT = 16;
    localparam int ADDR_W        = $clog2(ARC_ENTRIES);
    localparam int CNT_W         = $clog2(ARC_ENTRIES + 1);
    localparam int CFG_W         = 8;
    localparam int CMP_W         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SLOT_W        = 7;
    localparam int SLOT_CMP_W    = ((ADDR_W > SLOT_W) ? ADDR_W : SLOT_W) + 1;
    localparam int EPS_W         = $clog2(EPSILON_LIMIT + 1);

    // Special symbol and state codes
    localparam logic [7:0] SYM_EPSILON = 8'h26;
    localparam logic [7:0] STATE_NONE  = 8'h23;

    // Command and kind codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FEED = 1'b1;
    localparam logic [1:0] KIND_FINAL = 2'd2;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0] VERDICT_NO_ARC    = 3'd1;
    localparam logic [2:0] VERDICT_NONFINAL  = 3'd2;
    localparam logic [2:0] VERDICT_DEAD      = 3'd3;
    localparam logic [2:0] VERDICT_EPS_LIMIT = 3'd4;
    localparam logic [2:0] VERDICT_MISSING   = 3'd5;

    // One arc table entry
    typedef struct packed {
        logic [7:0] from;
        logic [7:0] sym;
        logic [7:0] to;
        logic [1:0] kind;
    } arc_t;

    localparam int ARC_W = $bits(arc_t);

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_MOVE  = 5'b00100,
        ST_FIRST = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

// ===== src/dfa_rec_ram.sv =====
module dfa_rec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/table_driven_dfa_recognizer_unit.sv =====
// Load transaction: taken while idle and written straight into the table; the next transaction may follow at once.
// Feed transaction: each move scans the first min(arcs_in_use, ARC_ENTRIES) table entries
// for a match, then for the new state's first arc, one entry per cycle; up to
// EPSILON_LIMIT + 1 moves per symbol, plus a start state per string and an emit state at its end.
// Reset clears the sequencer, the string status and the output stage; the arc
// table holds no defined contents until loaded and gets no clearing pass.
module table_driven_dfa_recognizer_unit
    import dfa_rec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic             command,
    input  logic [6:0]       arc_slot,
    input  logic [7:0]       arc_from,
    input  logic [7:0]       arc_symbol,
    input  logic [7:0]       arc_to,
    input  logic [1:0]       arc_kind,
    input  logic [7:0]       symbol,
    input  logic             last_symbol,
    output logic             result_valid,
    input  logic             result_stall,
    output logic             accepted,
    output logic [2:0]       verdict,
    output logic [7:0]       final_state
);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   arcs_reg;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [7:0]         cur_reg, cur_next;
    logic [7:0]         sym_reg, sym_next;
    logic               last_reg, last_next;
    logic               consumed_reg, consumed_next;
    logic [EPS_W-1:0]   eps_reg, eps_next;
    logic               open_reg, open_next;
    logic               decided_reg, decided_next;
    logic [2:0]         verdict_reg, verdict_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_acc_reg, out_acc_next;
    logic [2:0]         out_verdict_reg, out_verdict_next;
    logic [7:0]         out_state_reg, out_state_next;

    logic                  item_take;
    logic                  issue;
    logic                  wr_en;
    logic [SLOT_CMP_W-1:0] slot_wide;
    logic [ADDR_W-1:0]     raddr;
    logic [ARC_W-1:0]      rdata_raw;
    arc_t                  rd_arc;
    arc_t                  wr_arc;
    logic                  from_hit;
    logic                  sym_hit;
    logic                  eps_hit;
    logic                  fin;

    // Scanned entry count, saturated at the table depth
    assign used = (CMP_W'(arcs_reg) > CMP_W'(ARC_ENTRIES)) ?
                  CNT_W'(ARC_ENTRIES) : CNT_W'(arcs_reg);

    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && !item_stall;

    // Arc table write from load transactions
    assign slot_wide = SLOT_CMP_W'(arc_slot);
    assign wr_en     = item_take && (command == CMD_LOAD) &&
                       (slot_wide < SLOT_CMP_W'(ARC_ENTRIES));
    assign wr_arc    = '{from: arc_from, sym: arc_symbol, to: arc_to, kind: arc_kind};

    // Read address: entry zero while idle, scan pointer otherwise
    assign issue = (issue_reg < used);
    assign raddr = (state_reg == ST_IDLE) ? '0 : issue_reg[ADDR_W-1:0];

    dfa_rec_ram #(
        .WIDTH (ARC_W),
        .DEPTH (ARC_ENTRIES)
    ) u_arc_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_wide[ADDR_W-1:0]),
        .wdata (wr_arc),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rd_arc   = arc_t'(rdata_raw);
    assign from_hit = rd_valid_reg && (rd_arc.from == cur_reg);
    assign sym_hit  = (rd_arc.sym == sym_reg);
    assign eps_hit  = (rd_arc.sym == SYM_EPSILON);
    assign fin      = (rd_arc.kind == KIND_FINAL);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        issue_next       = issue_reg;
        rd_valid_next    = 1'b0;
        cur_next         = cur_reg;
        sym_next         = sym_reg;
        last_next        = last_reg;
        consumed_next    = consumed_reg;
        eps_next         = eps_reg;
        open_next        = open_reg;
        decided_next     = decided_reg;
        verdict_next     = verdict_reg;
        out_valid_next   = out_valid_reg && result_stall;
        out_acc_next     = out_acc_reg;
        out_verdict_next = out_verdict_reg;
        out_state_next   = out_state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Take a feed transaction; loads only write the table
                if (item_take && (command == CMD_FEED))
                begin
                    sym_next   = symbol;
                    last_next  = last_symbol;
                    eps_next   = '0;
                    issue_next = '0;
                    if (!open_reg)
                    begin
                        open_next    = 1'b1;
                        decided_next = 1'b0;
                        verdict_next = VERDICT_ACCEPT;
                        state_next   = ST_START;
                    end
                    else if (!decided_reg)
                    begin
                        state_next = ST_MOVE;
                    end
                    else if (last_symbol)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_START:
            begin
                // Enter the start state from entry zero
                cur_next   = rd_arc.from;
                issue_next = '0;
                state_next = ST_MOVE;
            end

            ST_MOVE:
            begin
                // Look for the first consuming or epsilon arc
                if (from_hit && (sym_hit || eps_hit))
                begin
                    if (!sym_hit && (eps_reg >= EPS_W'(EPSILON_LIMIT)))
                    begin
                        decided_next = 1'b1;
                        verdict_next = VERDICT_EPS_LIMIT;
                        state_next   = last_reg ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        eps_next      = sym_hit ? eps_reg : eps_reg + EPS_W'(1);
                        cur_next      = rd_arc.to;
                        consumed_next = sym_hit;
                        issue_next    = '0;
                        state_next    = ST_FIRST;
                    end
                end
                else if (!issue && !rd_valid_reg)
                begin
                    decided_next = 1'b1;
                    verdict_next = VERDICT_NO_ARC;
                    state_next   = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    rd_valid_next = issue;
                    issue_next    = issue ? issue_reg + CNT_W'(1) : issue_reg;
                end
            end

            ST_FIRST:
            begin
                // Classify the new state by its first leaving arc
                if (from_hit)
                begin
                    if (consumed_reg && last_reg)
                    begin
                        decided_next = 1'b1;
                        verdict_next = fin ? VERDICT_ACCEPT : VERDICT_NONFINAL;
                        state_next   = ST_EMIT;
                    end
                    else if (fin && (rd_arc.to == STATE_NONE))
                    begin
                        decided_next = 1'b1;
                        verdict_next = VERDICT_DEAD;
                        state_next   = last_reg ? ST_EMIT : ST_IDLE;
                    end
                    else if (consumed_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        issue_next = '0;
                        state_next = ST_MOVE;
                    end
                end
                else if (!issue && !rd_valid_reg)
                begin
                    decided_next = 1'b1;
                    verdict_next = VERDICT_MISSING;
                    state_next   = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    rd_valid_next = issue;
                    issue_next    = issue ? issue_reg + CNT_W'(1) : issue_reg;
                end
            end

            ST_EMIT:
            begin
                // Hand the verdict to the output stage and close the string
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_acc_next     = decided_reg && (verdict_reg == VERDICT_ACCEPT);
                    out_verdict_next = verdict_reg;
                    out_state_next   = cur_reg;
                    open_next        = 1'b0;
                    decided_next     = 1'b0;
                    verdict_next     = VERDICT_ACCEPT;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            arcs_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            issue_reg     <= '0;
            eps_reg       <= '0;
            cur_reg       <= '0;
            open_reg      <= 1'b0;
            decided_reg   <= 1'b0;
            verdict_reg   <= VERDICT_ACCEPT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wen)
            begin
                arcs_reg <= cfg_data;
            end
            rd_valid_reg  <= rd_valid_next;
            issue_reg     <= issue_next;
            eps_reg       <= eps_next;
            cur_reg       <= cur_next;
            open_reg      <= open_next;
            decided_reg   <= decided_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sym_reg         <= sym_next;
        last_reg        <= last_next;
        consumed_reg    <= consumed_next;
        out_acc_reg     <= out_acc_next;
        out_verdict_reg <= out_verdict_next;
        out_state_reg   <= out_state_next;
    end

    assign result_valid = out_valid_reg;
    assign accepted     = out_acc_reg;
    assign verdict      = out_verdict_reg;
    assign final_state  = out_state_reg;

endmodule

// ===== test/tb.sv =====
module tb;
    import dfa_rec_pkg::*;

    localparam logic [1:0] KIND_TRANSIT = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_SPARE   = 2'd3;

    localparam int ITEM_TARGET     = 1700;
    localparam int IDLE_PCT        = 18;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT  = 60000;
    localparam int MAX_REPORTS     = 40;
    localparam logic [7:0] DIRECTED_ARCS = 8'd8;

    // One input transaction, one field per port
    typedef struct {
        logic       cmd;
        logic [6:0] slot;
        logic [7:0] from;
        logic [7:0] sym;
        logic [7:0] to;
        logic [1:0] kind;
        logic [7:0] symbol;
        logic       last;
    } item_t;

    typedef struct {
        logic       acc;
        logic [2:0] vd;
        logic [7:0] st;
    } verdict_rec_t;

    typedef struct {
        item_t        it;
        bit           typed;
        verdict_rec_t want;
    } dir_row_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             cfg_wen      = 1'b0;
    logic [CFG_W-1:0] cfg_data     = '0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    logic             command      = CMD_LOAD;
    logic [6:0]       arc_slot     = '0;
    logic [7:0]       arc_from     = '0;
    logic [7:0]       arc_symbol   = '0;
    logic [7:0]       arc_to       = '0;
    logic [1:0]       arc_kind     = '0;
    logic [7:0]       symbol       = '0;
    logic             last_symbol  = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic             accepted;
    logic [2:0]       verdict;
    logic [7:0]       final_state;

    // Shared between the sender and the receiver
    verdict_rec_t pending_verdicts [$];
    verdict_rec_t unused_rec;
    int           items_sent     = 0;
    int           mismatch_count = 0;
    bit           calm           = 1'b0;
    bit           hold_req       = 1'b0;

    // Recognizer copy: table, register and string status
    arc_t       arc_tbl [ARC_ENTRIES];
    logic [7:0] arc_count  = '0;
    logic [7:0] cur_state  = '0;
    bit         decided    = 1'b0;
    logic [2:0] held_vd    = VERDICT_ACCEPT;
    bit         str_open   = 1'b0;

    table_driven_dfa_recognizer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .arc_slot     (arc_slot),
        .arc_from     (arc_from),
        .arc_symbol   (arc_symbol),
        .arc_to       (arc_to),
        .arc_kind     (arc_kind),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accepted     (accepted),
        .verdict      (verdict),
        .final_state  (final_state)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Number of table entries actually scanned
    function automatic int arc_span();
        return (arc_count > ARC_ENTRIES) ? ARC_ENTRIES : int'(arc_count);
    endfunction

    // Worst-case cycles for one symbol at the current table size
    function automatic int settle_cycles();
        return 2 * (arc_span() + 2) * (EPSILON_LIMIT + 1) + 32;
    endfunction

    function automatic int first_arc_from(logic [7:0] st);
        int i;
        for (i = 0; i < arc_span(); i++)
        begin
            if (arc_tbl[i].from == st)
                return i;
        end
        return -1;
    endfunction

    // Walk one symbol from cur_state; return a verdict code, or -1 while undecided
    function automatic int advance_symbol(logic [7:0] sym, logic last);
        int  eps_moves;
        int  hit;
        int  nxt;
        int  span;
        int  i;
        bit  consumed;
        bit  fin;
        eps_moves = 0;
        span = arc_span();
        while (1)
        begin
            hit = -1;
            consumed = 1'b0;
            for (i = 0; i < span; i++)
            begin
                if (arc_tbl[i].from == cur_state)
                begin
                    // the first consuming or epsilon arc wins; an '&' byte consumes on an epsilon arc
                    if (arc_tbl[i].sym == sym)
                    begin
                        hit = i;
                        consumed = 1'b1;
                        break;
                    end
                    if (arc_tbl[i].sym == SYM_EPSILON)
                    begin
                        hit = i;
                        break;
                    end
                end
            end
            if (hit < 0)
                return VERDICT_NO_ARC;
            if (!consumed)
            begin
                if (eps_moves >= EPSILON_LIMIT)
                    return VERDICT_EPS_LIMIT;
                eps_moves++;
            end
            cur_state = arc_tbl[hit].to;
            nxt = first_arc_from(cur_state);
            if (nxt < 0)
                return VERDICT_MISSING;
            fin = (arc_tbl[nxt].kind == KIND_FINAL);
            if (consumed && last)
                return fin ? VERDICT_ACCEPT : VERDICT_NONFINAL;
            if (fin && arc_tbl[nxt].to == STATE_NONE)
                return VERDICT_DEAD;
            if (consumed)
                return -1;
        end
        return -1;
    endfunction

    // Apply one accepted transaction; return 1 with the verdict on a string's last byte
    function automatic bit recognize_step(item_t it, output verdict_rec_t res);
        int v;
        if (it.cmd == CMD_LOAD)
        begin
            arc_tbl[it.slot] = {it.from, it.sym, it.to, it.kind};
            return 1'b0;
        end
        if (!str_open)
        begin
            str_open = 1'b1;
            decided = 1'b0;
            held_vd = VERDICT_ACCEPT;
            cur_state = arc_tbl[0].from;
        end
        // once rejected early, later bytes are ignored
        if (!decided)
        begin
            v = advance_symbol(it.symbol, it.last);
            if (v >= 0)
            begin
                decided = 1'b1;
                held_vd = v[2:0];
            end
        end
        if (!it.last)
            return 1'b0;
        res.acc = decided && (held_vd == VERDICT_ACCEPT);
        res.vd = held_vd;
        res.st = cur_state;
        str_open = 1'b0;
        decided = 1'b0;
        held_vd = VERDICT_ACCEPT;
        return 1'b1;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.cmd    = 1'($urandom);
        it.slot   = 7'($urandom);
        it.from   = 8'($urandom);
        it.sym    = 8'($urandom);
        it.to     = 8'($urandom);
        it.kind   = 2'($urandom);
        it.symbol = 8'($urandom);
        it.last   = 1'($urandom);
        return it;
    endfunction

    function automatic dir_row_t load_row(logic [6:0] slot, logic [7:0] from,
                                          logic [7:0] sym, logic [7:0] to, logic [1:0] kind);
        dir_row_t row;
        row.it = random_item();
        row.it.cmd = CMD_LOAD;
        row.it.slot = slot;
        row.it.from = from;
        row.it.sym = sym;
        row.it.to = to;
        row.it.kind = kind;
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic dir_row_t feed_row(logic [7:0] sym, logic last);
        dir_row_t row;
        row.it = random_item();
        row.it.cmd = CMD_FEED;
        row.it.symbol = sym;
        row.it.last = last;
        row.typed = 1'b0;
        return row;
    endfunction

    // Last byte of a string whose verdict is known by inspection
    function automatic dir_row_t verdict_row(logic [7:0] sym, logic acc, logic [2:0] vd,
                                             logic [7:0] st);
        dir_row_t row;
        row = feed_row(sym, 1'b1);
        row.typed = 1'b1;
        row.want.acc = acc;
        row.want.vd = vd;
        row.want.st = st;
        return row;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Offer one transaction, hold it until taken, then log what it should produce
    task automatic offer_item(item_t it, bit typed, verdict_rec_t typed_rec);
        verdict_rec_t res;
        bit           has_res;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= it.cmd;
        arc_slot    <= it.slot;
        arc_from    <= it.from;
        arc_symbol  <= it.sym;
        arc_to      <= it.to;
        arc_kind    <= it.kind;
        symbol      <= it.symbol;
        last_symbol <= it.last;
        do @(posedge clk); while (item_stall);
        items_sent++;
        has_res = recognize_step(it, res);
        if (has_res)
            pending_verdicts.push_back(typed ? typed_rec : res);
    endtask

    task automatic write_arc_count(logic [7:0] value);
        cfg_wen  <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        arc_count = value;
        cfg_wen  <= 1'b0;
    endtask

    // Drop valid and hold until every verdict is back
    task automatic drain_verdicts();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_verdicts.size() != 0);
    endtask

    // One table setting: reprogram, load a random automaton, then feed strings
    task automatic run_phase(logic [7:0] arc_n, int feed_items, bit fill_all, bit hold,
                             bit drain, bit steady);
        logic [7:0] pool [6];
        item_t      it;
        int         npool;
        int         nloads;
        int         fed;
        int         len;
        int         i;
        int         r;
        bit         drained;
        drain_verdicts();
        repeat (settle_cycles()) @(posedge clk);
        write_arc_count(arc_n);
        calm = steady;

        npool = $urandom_range(6, 2);
        for (i = 0; i < npool; i++)
            pool[i] = ($urandom_range(99) < 10) ? 8'($urandom) : 8'h41 + 8'(i);

        // load the scanned entries; each pool state gets its first arc early
        nloads = fill_all ? ARC_ENTRIES : ((arc_n > ARC_ENTRIES) ? ARC_ENTRIES : int'(arc_n));
        for (i = 0; i < nloads; i++)
        begin
            it = random_item();
            it.cmd = CMD_LOAD;
            it.slot = 7'(i);
            it.from = (i < npool) ? pool[i] : pool[$urandom_range(npool - 1)];
            r = $urandom_range(99);
            it.sym = (r < 75) ? 8'h61 + 8'($urandom_range(2)) :
                     (r < 85) ? SYM_EPSILON : 8'($urandom);
            r = $urandom_range(99);
            it.to = (r < 80) ? pool[$urandom_range(npool - 1)] :
                    (r < 90) ? STATE_NONE : 8'($urandom);
            r = $urandom_range(99);
            it.kind = (r < 40) ? KIND_TRANSIT : (r < 55) ? KIND_START :
                      (r < 90) ? KIND_FINAL : KIND_SPARE;
            offer_item(it, 1'b0, unused_rec);
        end

        if (hold)
            hold_req = 1'b1;

        fed = 0;
        drained = 1'b0;
        while (fed < feed_items)
        begin
            if (drain && !drained && fed >= feed_items / 2)
            begin
                drain_verdicts();
                drained = 1'b1;
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
            for (i = 0; i < len; i++)
            begin
                // stray load in the middle of a string
                if ($urandom_range(99) < 6)
                begin
                    it = random_item();
                    it.cmd = CMD_LOAD;
                    offer_item(it, 1'b0, unused_rec);
                    fed++;
                end
                it = random_item();
                it.cmd = CMD_FEED;
                r = $urandom_range(99);
                it.symbol = (r < 80) ? 8'h61 + 8'($urandom_range(2)) :
                            (r < 85) ? SYM_EPSILON : 8'($urandom);
                it.last = (i == len - 1);
                offer_item(it, 1'b0, unused_rec);
                fed++;
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: check each verdict transaction, then decide the next stall
    initial
    begin
        int           stall_left;
        verdict_rec_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected verdict %0d state %02h",
                                            verdict, final_state));
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (accepted !== want.acc)
                        flag_mismatch($sformatf("accepted %b, want %b", accepted, want.acc));
                    if (verdict !== want.vd)
                        flag_mismatch($sformatf("verdict %0d, want %0d", verdict, want.vd));
                    if (final_state !== want.st)
                        flag_mismatch($sformatf("final_state %02h, want %02h",
                                                final_state, want.st));
                end
            end
            if (hold_req)
            begin
                stall_left = HOLD_OFF_CYCLES;
                hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((item_valid && !item_stall) || (result_valid && !result_stall)))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        dir_row_t dir_rows [$];
        int       ph;

        // small automaton: S start, A transit, F final dead end, E/L epsilon loop
        dir_rows.push_back(load_row(7'd0, "S", "a", "A", KIND_START));
        dir_rows.push_back(load_row(7'd1, "S", SYM_EPSILON, "E", KIND_START));
        dir_rows.push_back(load_row(7'd2, "A", "b", "F", KIND_TRANSIT));
        dir_rows.push_back(load_row(7'd3, "A", SYM_EPSILON, "F", KIND_TRANSIT));
        dir_rows.push_back(load_row(7'd4, "F", "c", STATE_NONE, KIND_FINAL));
        dir_rows.push_back(load_row(7'd5, "E", "x", "Z", KIND_TRANSIT));
        dir_rows.push_back(load_row(7'd6, "E", SYM_EPSILON, "L", KIND_TRANSIT));
        dir_rows.push_back(load_row(7'd7, "L", SYM_EPSILON, "L", KIND_TRANSIT));
        // all-ones arc outside the scanned span
        dir_rows.push_back(load_row(7'd127, 8'hFF, 8'hFF, 8'hFF, KIND_SPARE));
        // plain accept, then nonfinal end
        dir_rows.push_back(feed_row("a", 1'b0));
        dir_rows.push_back(verdict_row("b", 1'b1, VERDICT_ACCEPT, "F"));
        dir_rows.push_back(verdict_row("a", 1'b0, VERDICT_NONFINAL, "A"));
        // dead final before the end; the trailing byte is ignored
        dir_rows.push_back(feed_row("a", 1'b0));
        dir_rows.push_back(feed_row("b", 1'b0));
        dir_rows.push_back(verdict_row("c", 1'b0, VERDICT_DEAD, "F"));
        // epsilon loop runs into the limit
        dir_rows.push_back(verdict_row("z", 1'b0, VERDICT_EPS_LIMIT, "L"));
        // move into a state with no leaving arc
        dir_rows.push_back(verdict_row("x", 1'b0, VERDICT_MISSING, "Z"));
        // an '&' byte consumes on an epsilon-symbol arc
        dir_rows.push_back(feed_row("a", 1'b0));
        dir_rows.push_back(verdict_row(SYM_EPSILON, 1'b1, VERDICT_ACCEPT, "F"));
        // epsilon move lands on a dead final
        dir_rows.push_back(feed_row("a", 1'b0));
        dir_rows.push_back(verdict_row("y", 1'b0, VERDICT_DEAD, "F"));
        // symbol extremes
        dir_rows.push_back(feed_row(8'h00, 1'b1));
        dir_rows.push_back(feed_row(8'hFF, 1'b1));

        // hold reset, then release at an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_arc_count(DIRECTED_ARCS);

        foreach (dir_rows[k])
            offer_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);

        // random automata over a range of table sizes
        ph = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (ph)
                0: run_phase(8'd128, 40, 1'b1, 1'b0, 1'b0, 1'b0);
                1: run_phase(8'd0, 20, 1'b0, 1'b0, 1'b0, 1'b0);
                2: run_phase(8'd10, 150, 1'b0, 1'b1, 1'b0, 1'b0);
                3: run_phase(8'd6, 150, 1'b0, 1'b0, 1'b1, 1'b0);
                4: run_phase(8'd16, 150, 1'b0, 1'b0, 1'b0, 1'b1);
                5: run_phase(8'd255, 30, 1'b0, 1'b0, 1'b0, 1'b0);
                6: run_phase(8'd1, 40, 1'b0, 1'b0, 1'b0, 1'b0);
                7: run_phase(8'd24, 150, 1'b0, 1'b0, 1'b0, 1'b0);
                default: run_phase(8'($urandom_range(40, 2)), 150, 1'b0, 1'b0, 1'b0, 1'b0);
            endcase
            ph++;
        end

        // wait out the last verdicts and any straggling work
        drain_verdicts();
        repeat (settle_cycles()) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== table_driven_dfa_recognizer_unit.f =====
src/dfa_rec_pkg.sv
src/dfa_rec_ram.sv
src/table_driven_dfa_recognizer_unit.sv
test/tb.sv
